// ===== rtl/frd_pkg.sv =====
// Shared types and constants for the failure recovery debouncer.
package frd_pkg;

  localparam int unsigned RunW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [RunW-1:0]   RunMax   = {RunW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [RunW-1:0]   ThreshReset = RunW'(3);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFailThresh = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRecvThresh = CfgIdxW'(1);

  typedef enum logic [1:0] {
    PH_HEALTHY   = 2'd0,
    PH_SUSPECTED = 2'd1,
    PH_OPEN      = 2'd2,
    PH_RECOVERED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_OPENED    = 2'd1,
    EV_RECOVERED = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEGATIVE = 2'd1,
    ST_ORDER    = 2'd2
  } status_t;

  // Debouncer state. Accepted timestamps are never negative, so the sign bit
  // is not stored.
  typedef struct packed {
    phase_t             phase;
    logic [RunW-1:0]    bad_run;
    logic [RunW-1:0]    good_run;
    logic [CountW-1:0]  generation;
    logic [TimeW-2:0]   last_time;
    logic               seen_any;
  } frd_state_t;

  typedef struct packed {
    logic [CountW-1:0] incident_count;
    phase_t            phase_now;
    event_t            event_code;
    status_t           status;
  } frd_result_t;

endpackage

// ===== rtl/failure_recovery_debouncer.sv =====
// Top level of the failure recovery debouncer: stream ports, state and result register.
// A result appears on the master side in the cycle after its observation is taken.
// Throughput: one observation per cycle while m_tready keeps up; the single pass of
// next-state logic in frd_step between the state and result registers sets that figure.
// Reset (rst, synchronous, active high): phase healthy, runs, incident count and last
// timestamp cleared, both thresholds back to 3, no result pending.
module failure_recovery_debouncer (
  input  logic        clk,
  input  logic        rst,
  // Observations. s_tdata fields from bit 0: health_bad[0], timestamp[32:1], zero fill.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // Results. m_tdata fields from bit 0: status[1:0], event_code[3:2],
  // phase_now[5:4], incident_count[37:6], zero fill.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // Configuration writes: index 0 is the bad-run threshold that opens an incident,
  // index 1 the good-run threshold that declares recovery.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [frd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [frd_pkg::RunW-1:0]         cfg_data
);

  frd_pkg::frd_state_t        state;
  frd_pkg::frd_state_t        state_next;
  frd_pkg::frd_result_t       result_next;
  frd_pkg::frd_result_t       result;
  logic [frd_pkg::RunW-1:0]   fail_limit;
  logic [frd_pkg::RunW-1:0]   recover_limit;
  logic                       s_take;

  // The result register frees up in the same cycle its transaction completes,
  // so observations stream at full rate while the downstream side keeps up.
  assign s_tready  = !m_tvalid || m_tready;
  assign s_take    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  frd_step u_step (
    .state         (state),
    .fail_limit    (fail_limit),
    .recover_limit (recover_limit),
    .health_bad    (s_tdata[0]),
    .timestamp     (s_tdata[frd_pkg::TimeW:1]),
    .state_next    (state_next),
    .result        (result_next)
  );

  // State, configuration and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      fail_limit    <= frd_pkg::ThreshReset;
      recover_limit <= frd_pkg::ThreshReset;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == frd_pkg::CfgFailThresh) begin
          fail_limit <= cfg_data;
        end else if (cfg_index == frd_pkg::CfgRecvThresh) begin
          recover_limit <= cfg_data;
        end
      end
      if (s_take) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only looked at under m_tvalid.
  always_ff @(posedge clk) begin
    if (s_take) begin
      result <= result_next;
    end
  end

  assign m_tdata = {2'b00, result};

endmodule

// ===== rtl/frd_step.sv =====
// Next-state and result logic for one health observation.
module frd_step (
  input  frd_pkg::frd_state_t         state,
  input  logic [frd_pkg::RunW-1:0]    fail_limit,
  input  logic [frd_pkg::RunW-1:0]    recover_limit,
  input  logic                        health_bad,
  input  logic [frd_pkg::TimeW-1:0]   timestamp,
  output frd_pkg::frd_state_t         state_next,
  output frd_pkg::frd_result_t        result
);

  logic [frd_pkg::RunW-1:0]   bad_inc;
  logic [frd_pkg::RunW-1:0]   good_inc;
  logic [frd_pkg::CountW-1:0] gen_inc;
  logic                       first_opens;
  logic                       negative;
  logic                       out_of_order;

  assign bad_inc  = (state.bad_run == frd_pkg::RunMax) ? state.bad_run
                                                       : state.bad_run + 1'b1;
  assign good_inc = (state.good_run == frd_pkg::RunMax) ? state.good_run
                                                        : state.good_run + 1'b1;
  assign gen_inc  = (state.generation == frd_pkg::CountMax) ? state.generation
                                                            : state.generation + 1'b1;
  // A run of one already meets a threshold of one (or zero).
  assign first_opens  = (fail_limit <= frd_pkg::RunW'(1));
  assign negative     = timestamp[frd_pkg::TimeW-1];
  assign out_of_order = state.seen_any &&
                        (timestamp[frd_pkg::TimeW-2:0] < state.last_time);

  always_comb begin
    state_next        = state;
    result.status     = frd_pkg::ST_OK;
    result.event_code = frd_pkg::EV_NONE;

    if (negative) begin
      result.status = frd_pkg::ST_NEGATIVE;
    end else if (out_of_order) begin
      result.status = frd_pkg::ST_ORDER;
    end else begin
      state_next.last_time = timestamp[frd_pkg::TimeW-2:0];
      state_next.seen_any  = 1'b1;
      case (state.phase)
        frd_pkg::PH_HEALTHY, frd_pkg::PH_RECOVERED: begin
          state_next.good_run = '0;
          if (health_bad) begin
            state_next.bad_run = frd_pkg::RunW'(1);
            if (first_opens) begin
              state_next.phase      = frd_pkg::PH_OPEN;
              state_next.generation = gen_inc;
              result.event_code     = frd_pkg::EV_OPENED;
            end else begin
              state_next.phase = frd_pkg::PH_SUSPECTED;
            end
          end else begin
            state_next.phase = frd_pkg::PH_HEALTHY;
          end
        end
        frd_pkg::PH_SUSPECTED: begin
          if (!health_bad) begin
            state_next.phase   = frd_pkg::PH_HEALTHY;
            state_next.bad_run = '0;
          end else begin
            state_next.bad_run = bad_inc;
            if (bad_inc >= fail_limit) begin
              state_next.phase      = frd_pkg::PH_OPEN;
              state_next.good_run   = '0;
              state_next.generation = gen_inc;
              result.event_code     = frd_pkg::EV_OPENED;
            end
          end
        end
        frd_pkg::PH_OPEN: begin
          if (health_bad) begin
            state_next.good_run = '0;
          end else begin
            state_next.good_run = good_inc;
            if (good_inc >= recover_limit) begin
              state_next.phase   = frd_pkg::PH_RECOVERED;
              state_next.bad_run = '0;
              result.event_code  = frd_pkg::EV_RECOVERED;
            end
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end

    result.phase_now      = state_next.phase;
    result.incident_count = state_next.generation;
  end

endmodule

// ===== verif/frd_tb_pkg.sv =====
// Scoreboard for the failure recovery debouncer: its own debouncer state and a queue of due results.
`timescale 1ns / 1ps

package frd_tb_pkg;

  import frd_pkg::*;

  class frd_scoreboard;

    logic [RunW-1:0]   fail_thr;
    logic [RunW-1:0]   recv_thr;
    phase_t            phase;
    logic [RunW-1:0]   bad_run;
    logic [RunW-1:0]   good_run;
    logic [CountW-1:0] generation;
    logic [TimeW-1:0]  last_ts;
    bit                seen_any;
    frd_result_t       due_results[$];
    int unsigned       errors;
    int unsigned       results_checked;
    int unsigned       opened_seen;
    int unsigned       recovered_seen;
    int unsigned       negative_seen;
    int unsigned       order_seen;

    function new();
      fail_thr = ThreshReset;
      recv_thr = ThreshReset;
      phase = PH_HEALTHY;
      bad_run = '0;
      good_run = '0;
      generation = '0;
      last_ts = '0;
      seen_any = 1'b0;
      errors = 0;
      results_checked = 0;
      opened_seen = 0;
      recovered_seen = 0;
      negative_seen = 0;
      order_seen = 0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [RunW-1:0] value);
      if (idx == CfgFailThresh) begin
        fail_thr = value;
      end else if (idx == CfgRecvThresh) begin
        recv_thr = value;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function event_t open_incident();
      phase = PH_OPEN;
      good_run = '0;
      if (generation != CountMax) generation++;
      return EV_OPENED;
    endfunction

    // A fresh bad run; a threshold of 0 or 1 opens on the very first bad sample.
    function event_t start_failure();
      bad_run = RunW'(1);
      good_run = '0;
      if (fail_thr <= RunW'(1)) return open_incident();
      phase = PH_SUSPECTED;
      return EV_NONE;
    endfunction

    function void take_observation(input logic [39:0] data);
      logic              bad;
      logic [TimeW-1:0]  ts;
      frd_result_t       r;
      bad = data[0];
      ts = data[TimeW:1];
      r.status = ST_OK;
      r.event_code = EV_NONE;
      if (ts[TimeW-1]) begin
        r.status = ST_NEGATIVE;
      end else if (seen_any && ts < last_ts) begin
        r.status = ST_ORDER;
      end else begin
        last_ts = ts;
        seen_any = 1'b1;
        case (phase)
          PH_HEALTHY: begin
            if (bad) r.event_code = start_failure();
          end
          PH_SUSPECTED: begin
            if (!bad) begin
              phase = PH_HEALTHY;
              bad_run = '0;
            end else begin
              if (bad_run != RunMax) bad_run++;
              if (bad_run >= fail_thr) r.event_code = open_incident();
            end
          end
          PH_OPEN: begin
            if (bad) begin
              good_run = '0;
            end else begin
              if (good_run != RunMax) good_run++;
              if (good_run >= recv_thr) begin
                phase = PH_RECOVERED;
                bad_run = '0;
                r.event_code = EV_RECOVERED;
              end
            end
          end
          default: begin
            good_run = '0;
            if (!bad) phase = PH_HEALTHY;
            else r.event_code = start_failure();
          end
        endcase
      end
      r.phase_now = phase;
      r.incident_count = generation;
      due_results.push_back(r);
    endfunction

    function void report_field(input string name, input logic [CountW-1:0] want,
                               input logic [CountW-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function void check_result(input logic [39:0] data);
      frd_result_t got;
      frd_result_t want;
      got = data[37:0];
      results_checked++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: expected none, actual %h", $time, data);
        return;
      end
      want = due_results.pop_front();
      if (want.event_code == EV_OPENED) opened_seen++;
      if (want.event_code == EV_RECOVERED) recovered_seen++;
      if (want.status == ST_NEGATIVE) negative_seen++;
      if (want.status == ST_ORDER) order_seen++;
      if (got.status !== want.status)
        report_field("status", CountW'(want.status), CountW'(got.status));
      if (got.event_code !== want.event_code)
        report_field("event_code", CountW'(want.event_code), CountW'(got.event_code));
      if (got.phase_now !== want.phase_now)
        report_field("phase_now", CountW'(want.phase_now), CountW'(got.phase_now));
      if (got.incident_count !== want.incident_count)
        report_field("incident_count", want.incident_count, got.incident_count);
    endfunction

  endclass

endpackage

// ===== verif/tb_failure_recovery_debouncer.sv =====
// Top level of the testbench for the failure recovery debouncer: clock, reset, drivers, checks.
`timescale 1ns / 1ps

module tb_failure_recovery_debouncer;

  import frd_pkg::*;
  import frd_tb_pkg::*;

  // A correct run takes about 1600 observations; even under the heaviest stalls,
  // this bound leaves a wide margin on top of that.
  localparam int unsigned CycleLimit = 100_000;

  // Indexes that hit no register; writes to them must leave both thresholds alone.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = '1;

  localparam logic [TimeW-1:0] TimeMax = {1'b0, {(TimeW-1){1'b1}}};
  localparam logic             Good    = 1'b0;
  localparam logic             Bad     = 1'b1;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [39:0]        m_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RunW-1:0]    cfg_data = '0;

  // Percent of cycles in which each side holds back.
  int unsigned        send_idle_pct = 10;
  int unsigned        recv_idle_pct = 66;

  // Latest timestamp handed out as a valid one, and the thresholds now programmed;
  // the stimulus uses them to shape runs and to build rejected timestamps.
  logic [TimeW-1:0]   ts_now = '0;
  logic [RunW-1:0]    cur_fail = ThreshReset;
  logic [RunW-1:0]    cur_recv = ThreshReset;

  int unsigned        cycles = 0;
  frd_scoreboard      sb = new();

  failure_recovery_debouncer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // health_bad[0], timestamp[32:1], zero fill
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // status[1:0], event_code[3:2], phase_now[5:4], incident_count[37:6]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether to take a result.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every handshake is seen here, at the edge where it completes. Inputs are driven
  // with nonblocking assignments, so these reads see the values of the closing cycle.
  // The result is checked before the new observation is noted, since a result can
  // never belong to an observation taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.take_observation(s_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // One observation transaction. The sender may first hold back with tvalid low;
  // when it does not, tvalid simply stays high from the previous transaction.
  task automatic send_obs(input logic bad, input logic [TimeW-1:0] ts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, ts, bad};
    do @(posedge clk); while (!s_tready);
  endtask

  // A timestamp that is accepted: equal to or a little past the last one, now and
  // then a long jump so that the upper bits move too.
  task automatic send_next(input logic bad);
    logic [TimeW-1:0] ts;
    if (ts_now < 32'h1000_0000 && $urandom_range(0, 99) == 0) begin
      ts = ts_now + $urandom_range(0, 1 << 20);
    end else begin
      ts = ts_now + $urandom_range(0, 3);
    end
    ts_now = ts;
    send_obs(bad, ts);
  endtask

  // A rejected observation: negative, or older than the last accepted timestamp.
  task automatic send_noise();
    logic [TimeW-1:0] ts;
    if (ts_now != 0 && $urandom_range(0, 1) == 1) begin
      ts = $urandom_range(0, ts_now - 1);
    end else begin
      ts = $urandom | 32'h8000_0000;
    end
    send_obs(logic'($urandom_range(0, 1)), ts);
  endtask

  // The sender stops until every result it caused has been checked. Each observation
  // yields exactly one result, so an empty queue means the block is idle. The first
  // look comes at the falling edge, after the last accepted observation is noted.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [RunW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Both thresholds, then a write to an index with no register behind it.
  task automatic set_thresholds(input logic [RunW-1:0] fail_thr, input logic [RunW-1:0] recv_thr);
    cfg_write(CfgFailThresh, fail_thr);
    cfg_write(CfgRecvThresh, recv_thr);
    cfg_write(($urandom_range(0, 1) == 1) ? CfgIdxSpare : CfgIdxTop, RunW'($urandom));
    cfg_valid <= 1'b0;
    cur_fail = fail_thr;
    cur_recv = recv_thr;
  endtask

  // Runs of bad and of good samples with lengths around the thresholds, so that the
  // block walks through every phase. A few runs carry random health values, and
  // rejected observations are sprinkled in without counting toward the total.
  task automatic run_random(input int unsigned count);
    int unsigned accepted_ok;
    int unsigned run_len;
    logic        bad;
    bit          mixed;
    accepted_ok = 0;
    bad = logic'($urandom_range(0, 1));
    while (accepted_ok < count) begin
      run_len = $urandom_range(1, (bad ? cur_fail : cur_recv) + 2);
      mixed = ($urandom_range(0, 7) == 0);
      repeat (run_len) begin
        if ($urandom_range(0, 99) < 6) send_noise();
        send_next(mixed ? logic'($urandom_range(0, 1)) : bad);
        accepted_ok++;
      end
      if ($urandom_range(0, 3) != 0) bad = ~bad;
    end
  endtask

  initial begin
    int mode;
    int chunk;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds of three. Negative timestamps before anything is accepted,
    // a first accepted sample at time zero, an equal timestamp, an out-of-order one,
    // a bad sample while open, and a failure run started from recovered.
    send_obs(Good, 32'h8000_0000);
    send_obs(Bad,  32'hFFFF_FFFF);
    send_obs(Good, 32'd0);
    send_obs(Bad,  32'd5);
    send_obs(Good, 32'd5);
    send_obs(Bad,  32'd6);
    send_obs(Bad,  32'd7);
    send_obs(Bad,  32'd7);
    send_obs(Good, 32'd3);
    send_obs(Good, 32'd8);
    send_obs(Bad,  32'd9);
    send_obs(Good, 32'd10);
    send_obs(Good, 32'd11);
    send_obs(Good, 32'd12);
    send_obs(Good, 32'd13);
    send_obs(Bad,  32'd14);
    send_obs(Bad,  32'd15);
    send_obs(Bad,  32'd16);
    send_obs(Good, 32'd17);
    send_obs(Good, 32'd18);
    send_obs(Good, 32'd19);
    send_obs(Bad,  32'd20);
    send_obs(Bad,  32'd21);
    send_obs(Bad,  32'd22);
    ts_now = 32'd22;

    // Thresholds of one: a single bad sample opens from healthy and from recovered.
    wait_for_results();
    set_thresholds(RunW'(1), RunW'(1));
    send_next(Bad);
    send_next(Good);
    send_next(Bad);
    send_next(Good);
    send_next(Good);
    send_next(Bad);

    // Thresholds of zero must act exactly like thresholds of one.
    wait_for_results();
    set_thresholds('0, '0);
    send_next(Good);
    send_next(Bad);
    send_next(Bad);
    send_next(Good);
    send_next(Good);
    send_next(Bad);
    send_next(Good);

    // Random runs under three idling mixes, with fresh thresholds every chunk. Each
    // new setting is preceded by a pause that lets all results drain.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (chunk = 0; chunk < 4; chunk++) begin
        wait_for_results();
        set_thresholds(RunW'($urandom_range(1, 6)), RunW'($urandom_range(1, 6)));
        run_random(120);
      end
    end

    // Largest thresholds: get to healthy under thresholds of one first, then a long
    // run of bad samples stays suspected and a good one returns to healthy.
    wait_for_results();
    set_thresholds(RunW'(1), RunW'(1));
    send_next(Good);
    send_next(Good);
    wait_for_results();
    set_thresholds(RunMax, RunMax);
    repeat (40) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_next(Bad);
    end
    send_next(Good);
    send_next(Good);

    // Largest timestamp last, since nothing smaller is accepted after it.
    send_obs(Good, TimeMax);
    send_obs(Bad,  TimeMax - 1);
    send_obs(Bad,  TimeMax);
    send_obs(Good, 32'h8000_0001);

    wait_for_results();
    repeat (4) @(posedge clk);

    $display("Checked %0d results: %0d opened, %0d recovered, %0d negative, %0d out of order.",
             sb.results_checked, sb.opened_seen, sb.recovered_seen, sb.negative_seen,
             sb.order_seen);
    $display("Thresholds ranged from 0 to 65535 under three stall mixes on the two streams.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== failure_recovery_debouncer.f =====
rtl/frd_pkg.sv
rtl/frd_step.sv
rtl/failure_recovery_debouncer.sv
verif/frd_tb_pkg.sv
verif/tb_failure_recovery_debouncer.sv
